// ===== rtl/bblru_pkg.sv =====
// shared widths, entry layout and controller/datapath signal groups
package bblru_pkg;

  localparam int KEY_W     = 64;
  localparam int SIZE_W    = 48;
  localparam int STAMP_W   = 32;
  localparam int PL_W      = 32;
  localparam int EVICT_W   = 5;
  localparam int TOTAL_W   = 52;

  localparam logic [SIZE_W-1:0]  BUDGET_RESET = 48'd536870912;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};
  localparam logic [EVICT_W-1:0] EVICT_MAX    = {EVICT_W{1'b1}};

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SIZE_W-1:0]  bytes;
    logic [STAMP_W-1:0] stamp;
    logic [PL_W-1:0]    payload;
  } bblru_entry_t;

  localparam int ENTRY_W = $bits(bblru_entry_t);

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic start_scan;
    logic scan_key;
    logic restamp;
    logic drop_old;
    logic insert;
    logic load_out;
  } bblru_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic free_found;
    logic old_found;
    logic over_budget;
    logic is_insert;
    logic out_free;
  } bblru_sts_t;

endpackage

// ===== rtl/bblru_in_if.sv =====
// input word channel: valid, ready and the item fields
interface bblru_in_if import bblru_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [KEY_W-1:0]   key;
  logic [SIZE_W-1:0]  size_bytes;
  logic [PL_W-1:0]    payload;

  modport source (output valid, mode, key, size_bytes, payload, input ready);
  modport sink   (input valid, mode, key, size_bytes, payload, output ready);
endinterface

// ===== rtl/bblru_out_if.sv =====
// result word channel: valid, ready and the result fields
interface bblru_out_if import bblru_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [PL_W-1:0]    payload_out;
  logic [EVICT_W-1:0] evicted_count;
  logic [TOTAL_W-1:0] total_bytes_out;

  modport source (output valid, hit, payload_out, evicted_count, total_bytes_out,
                  input ready);
  modport sink   (input valid, hit, payload_out, evicted_count, total_bytes_out,
                  output ready);
endinterface

// ===== rtl/bblru_ram.sv =====
// generic single write port, single read port ram with registered read
module bblru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bblru_dp.sv =====
// datapath: entry ram, valid bits, scan pipeline, totals and result register
module bblru_dp import bblru_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SIZE_W-1:0]  cfg_wdata_i,
  input  logic               mode_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [SIZE_W-1:0]  size_bytes_i,
  input  logic [PL_W-1:0]    payload_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               hit_o,
  output logic [PL_W-1:0]    payload_out_o,
  output logic [EVICT_W-1:0] evicted_count_o,
  output logic [TOTAL_W-1:0] total_bytes_out_o,
  input  bblru_cmd_t         cmd_i,
  output bblru_sts_t         sts_o
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int TW  = SIZE_W + IW;
  localparam int CW  = $clog2(ENTRIES + 2);
  localparam int TXW = (TW > TOTAL_W) ? TW : TOTAL_W;
  localparam int CXW = (CW > EVICT_W) ? CW : EVICT_W;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  // control state
  logic [SIZE_W-1:0]  budget_q, budget_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [TW-1:0]      total_q, total_d;
  logic [STAMP_W-1:0] use_q, use_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;
  logic               rd_on_q, rd_on_d;
  logic [IW-1:0]      chk_idx_q, chk_idx_d;
  logic               chk_on_q, chk_on_d;
  logic               done_q, done_d;
  logic               skey_q, skey_d;
  logic               hit_q, hit_d;
  logic               free_q, free_d;
  logic               old_q, old_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;

  // payload state
  logic               mode_q, mode_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [PL_W-1:0]    pl_q, pl_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  bblru_entry_t       hit_ent_q, hit_ent_d;
  logic [IW-1:0]      free_idx_q, free_idx_d;
  logic [IW-1:0]      old_idx_q, old_idx_d;
  logic [STAMP_W-1:0] old_stamp_q, old_stamp_d;
  logic [SIZE_W-1:0]  old_bytes_q, old_bytes_d;
  logic               out_hit_q, out_hit_d;
  logic [PL_W-1:0]    out_pl_q, out_pl_d;
  logic [EVICT_W-1:0] out_ev_q, out_ev_d;
  logic [TOTAL_W-1:0] out_tot_q, out_tot_d;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  bblru_entry_t       ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  bblru_entry_t       rent;
  logic               cv;
  logic [IW-1:0]      slot;
  logic [STAMP_W-1:0] use_inc;
  logic [TXW-1:0]     tot_x;
  logic [CXW-1:0]     cnt_x;

  bblru_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_on_q),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign rent    = ram_rdata;
  assign cv      = valid_q[chk_idx_q];
  assign use_inc = use_q + 1'b1;
  assign slot    = free_q ? free_idx_q : old_idx_q;
  assign tot_x   = TXW'(total_q);
  assign cnt_x   = CXW'(cnt_q);

  always_comb begin
    budget_d    = budget_q;
    valid_d     = valid_q;
    total_d     = total_q;
    use_d       = use_q;
    rd_idx_d    = rd_idx_q;
    rd_on_d     = rd_on_q;
    chk_idx_d   = rd_idx_q;
    chk_on_d    = rd_on_q;
    done_d      = done_q;
    skey_d      = skey_q;
    hit_d       = hit_q;
    free_d      = free_q;
    old_d       = old_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    mode_d      = mode_q;
    key_d       = key_q;
    size_d      = size_q;
    pl_d        = pl_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    free_idx_d  = free_idx_q;
    old_idx_d   = old_idx_q;
    old_stamp_d = old_stamp_q;
    old_bytes_d = old_bytes_q;
    out_hit_d   = out_hit_q;
    out_pl_d    = out_pl_q;
    out_ev_d    = out_ev_q;
    out_tot_d   = out_tot_q;
    ram_we      = 1'b0;
    ram_waddr   = hit_idx_q;
    ram_wdata   = hit_ent_q;

    if (cfg_we_i) begin
      budget_d = cfg_wdata_i;
    end

    if (cmd_i.capture) begin
      mode_d = mode_i;
      key_d  = key_i;
      size_d = size_bytes_i;
      pl_d   = payload_i;
      cnt_d  = '0;
    end

    // read stage walks the addresses, check stage sees the registered ram data for each address
    if (rd_on_q) begin
      if (rd_idx_q == LastIdx) begin
        rd_on_d = 1'b0;
      end else begin
        rd_idx_d = rd_idx_q + 1'b1;
      end
    end
    if (chk_on_q && chk_idx_q == LastIdx) begin
      done_d = 1'b1;
    end
    if (chk_on_q && cv) begin
      if (skey_q && rent.key == key_q) begin
        hit_d     = 1'b1;
        hit_idx_d = chk_idx_q;
        hit_ent_d = rent;
      end
      // strict compare keeps the lowest slot among equal stamps
      if (!old_q || rent.stamp < old_stamp_q) begin
        old_d       = 1'b1;
        old_idx_d   = chk_idx_q;
        old_stamp_d = rent.stamp;
        old_bytes_d = rent.bytes;
      end
    end
    if (chk_on_q && !cv && skey_q && !free_q) begin
      free_d     = 1'b1;
      free_idx_d = chk_idx_q;
    end

    if (cmd_i.start_scan) begin
      rd_idx_d = '0;
      rd_on_d  = 1'b1;
      chk_on_d = 1'b0;
      done_d   = 1'b0;
      skey_d   = cmd_i.scan_key;
      old_d    = 1'b0;
      if (cmd_i.scan_key) begin
        hit_d  = 1'b0;
        free_d = 1'b0;
      end
    end

    if (cmd_i.restamp) begin
      use_d           = use_inc;
      ram_we          = 1'b1;
      ram_waddr       = hit_idx_q;
      ram_wdata       = hit_ent_q;
      ram_wdata.stamp = use_inc;
    end

    if (cmd_i.drop_old) begin
      valid_d[old_idx_q] = 1'b0;
      total_d            = total_q - TW'(old_bytes_q);
      cnt_d              = cnt_q + 1'b1;
    end

    if (cmd_i.insert) begin
      valid_d[slot]     = 1'b1;
      use_d             = use_inc;
      total_d           = total_q + TW'(size_q);
      ram_we            = 1'b1;
      ram_waddr         = slot;
      ram_wdata.key     = key_q;
      ram_wdata.bytes   = size_q;
      ram_wdata.stamp   = use_inc;
      ram_wdata.payload = pl_q;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      out_hit_d   = hit_q;
      out_pl_d    = (!mode_q && hit_q) ? hit_ent_q.payload : '0;
      out_ev_d    = (cnt_x > CXW'(EVICT_MAX)) ? EVICT_MAX : cnt_x[EVICT_W-1:0];
      out_tot_d   = (tot_x > TXW'(TOTAL_MAX)) ? TOTAL_MAX : tot_x[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q    <= BUDGET_RESET;
      valid_q     <= '0;
      total_q     <= '0;
      use_q       <= '0;
      rd_idx_q    <= '0;
      rd_on_q     <= 1'b0;
      chk_idx_q   <= '0;
      chk_on_q    <= 1'b0;
      done_q      <= 1'b0;
      skey_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      old_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      budget_q    <= budget_d;
      valid_q     <= valid_d;
      total_q     <= total_d;
      use_q       <= use_d;
      rd_idx_q    <= rd_idx_d;
      rd_on_q     <= rd_on_d;
      chk_idx_q   <= chk_idx_d;
      chk_on_q    <= chk_on_d;
      done_q      <= done_d;
      skey_q      <= skey_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      old_q       <= old_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    key_q       <= key_d;
    size_q      <= size_d;
    pl_q        <= pl_d;
    hit_idx_q   <= hit_idx_d;
    hit_ent_q   <= hit_ent_d;
    free_idx_q  <= free_idx_d;
    old_idx_q   <= old_idx_d;
    old_stamp_q <= old_stamp_d;
    old_bytes_q <= old_bytes_d;
    out_hit_q   <= out_hit_d;
    out_pl_q    <= out_pl_d;
    out_ev_q    <= out_ev_d;
    out_tot_q   <= out_tot_d;
  end

  always_comb begin
    sts_o.scan_done   = done_q;
    sts_o.hit         = hit_q;
    sts_o.free_found  = free_q;
    sts_o.old_found   = old_q;
    sts_o.over_budget = total_q > TW'(budget_q);
    sts_o.is_insert   = mode_q;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = out_hit_q;
  assign payload_out_o     = out_pl_q;
  assign evicted_count_o   = out_ev_q;
  assign total_bytes_out_o = out_tot_q;

endmodule

// ===== rtl/bblru_ctrl.sv =====
// controller: sequences key scan, insert, eviction scans and result hand-off
module bblru_ctrl import bblru_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output bblru_cmd_t cmd_o,
  input  bblru_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KSCAN,
    ST_DROP,
    ST_INSERT,
    ST_CHECK,
    ST_OSCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture    = 1'b1;
          cmd_o.start_scan = 1'b1;
          cmd_o.scan_key   = 1'b1;
          state_d          = ST_KSCAN;
        end
      end
      ST_KSCAN: begin
        if (sts_i.scan_done) begin
          priority if (!sts_i.is_insert) begin
            cmd_o.restamp = sts_i.hit;
            state_d       = ST_FINISH;
          end else if (sts_i.hit) begin
            state_d = ST_FINISH;
          end else if (sts_i.free_found) begin
            state_d = ST_INSERT;
          end else begin
            state_d = ST_DROP;
          end
        end
      end
      // table full: oldest entry makes room
      ST_DROP: begin
        cmd_o.drop_old = 1'b1;
        state_d        = ST_INSERT;
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.over_budget) begin
          cmd_o.start_scan = 1'b1;
          state_d          = ST_OSCAN;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_OSCAN: begin
        if (sts_i.scan_done) begin
          if (sts_i.old_found) begin
            cmd_o.drop_old = 1'b1;
            state_d        = ST_CHECK;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/byte_budget_lru_cache.sv =====
// lookup: the result word follows a full key scan of the entry ram read port at one entry
// per cycle; the next lookup is taken only after the result is loaded
// insert of an absent key: a drop step when full, and a further scan per budget eviction
// one item in flight; the next word is taken while the result register waits
// reset clears valid bits, byte total, use counter and sets the budget to 512 MiB;
// ram contents are not cleared and no clearing pass runs
module byte_budget_lru_cache import bblru_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  bblru_in_if.sink          in_i,
  bblru_out_if.source       out_o
);

  bblru_cmd_t cmd;
  bblru_sts_t sts;

  bblru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bblru_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .mode_i            (in_i.mode),
    .key_i             (in_i.key),
    .size_bytes_i      (in_i.size_bytes),
    .payload_i         (in_i.payload),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .hit_o             (out_o.hit),
    .payload_out_o     (out_o.payload_out),
    .evicted_count_o   (out_o.evicted_count),
    .total_bytes_out_o (out_o.total_bytes_out),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule
